// ===== rtl/msr_pkg.sv =====
// shared types, codes and sizes of the servo sweep ramp generator
`default_nettype none
package msr_pkg;

    localparam int BOARDS = 4;
    localparam int SERVOS = 16;
    localparam int SLOTS  = BOARDS * SERVOS;
    localparam int SLOT_W = $clog2(SLOTS);

    localparam logic [1:0] KIND_START    = 2'd0;
    localparam logic [1:0] KIND_STOP     = 2'd1;
    localparam logic [1:0] KIND_STOP_ALL = 2'd2;
    localparam logic [1:0] KIND_UPDATE   = 2'd3;

    localparam logic [2:0] ST_POSITION = 3'd0;
    localparam logic [2:0] ST_ACK      = 3'd1;
    localparam logic [2:0] ST_BAD_IDX  = 3'd2;
    localparam logic [2:0] ST_DISABLED = 3'd3;
    localparam logic [2:0] ST_ZERO_DUR = 3'd4;
    localparam logic [2:0] ST_NO_SLOT  = 3'd5;
    localparam logic [2:0] ST_IDLE     = 3'd6;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         board;
        logic [3:0]         servo;
        logic signed [15:0] start_pos;
        logic signed [15:0] end_pos;
        logic [31:0]        duration_ms;
        logic [31:0]        now_ms;
        logic               servo_enabled;
        logic signed [15:0] limit_center;
        logic [14:0]        limit_range;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [1:0]         out_board;
        logic [3:0]         out_servo;
        logic signed [15:0] position;
        logic               finished;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [1:0]         board;
        logic [3:0]         servo;
        logic signed [15:0] start_pos;
        logic signed [15:0] end_pos;
        logic [31:0]        start_time;
        logic [31:0]        duration;
    } t_slot;

endpackage
`default_nettype wire

// ===== rtl/msr_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module msr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/msr_interp.sv =====
// bit-serial multiply and divide for one ramp interpolation
`default_nettype none
module msr_interp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [15:0] i_a,
    input  wire logic signed [15:0] i_b,
    input  wire logic [31:0]        i_el,
    input  wire logic [31:0]        i_dur,
    output logic                    o_done,
    output logic signed [15:0]      o_pos
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]         r_phase, n_phase;
    logic [3:0]         r_cnt, n_cnt;
    logic [47:0]        r_p, n_p;
    logic               r_neg, n_neg;
    logic signed [15:0] r_a, n_a;
    logic [31:0]        r_el, n_el;
    logic [31:0]        r_dur, n_dur;

    logic [16:0] w_diff, w_mag;
    logic [32:0] w_sum, w_t, w_tsub;
    logic        w_ge;
    logic [17:0] w_q, w_res;

    always_comb begin
        w_diff = {i_b[15], i_b} - {i_a[15], i_a};
        w_mag  = w_diff[16] ? (17'd0 - w_diff) : w_diff;
        w_sum  = {1'b0, r_p[47:16]} + (r_p[0] ? {1'b0, r_el} : 33'd0);
        w_t    = {r_p[47:16], r_p[15]};
        w_ge   = (w_t >= {1'b0, r_dur});
        w_tsub = w_t - {1'b0, r_dur};
        w_q    = {2'b00, r_p[15:0]};
        w_res  = {r_a[15], r_a[15], r_a} + (r_neg ? (18'd0 - w_q) : w_q);
        if ($signed(w_res) > $signed(18'sd32767)) begin
            o_pos = 16'sh7fff;
        end else if ($signed(w_res) < -$signed(18'sd32768)) begin
            o_pos = 16'sh8000;
        end else begin
            o_pos = w_res[15:0];
        end
        o_done = (r_phase == PH_DONE);
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_p     = r_p;
        n_neg   = r_neg;
        n_a     = r_a;
        n_el    = r_el;
        n_dur   = r_dur;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_p     = {32'd0, w_mag[15:0]};
                    n_neg   = w_diff[16];
                    n_a     = i_a;
                    n_el    = i_el;
                    n_dur   = i_dur;
                    n_cnt   = 4'd0;
                    n_phase = PH_MUL;
                end
            end
            PH_MUL: begin
                n_p   = {w_sum, r_p[15:1]};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_phase = PH_DIV;
                end
            end
            PH_DIV: begin
                n_p   = {(w_ge ? w_tsub[31:0] : w_t[31:0]), r_p[14:0], w_ge};
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
        r_p   <= n_p;
        r_neg <= n_neg;
        r_a   <= n_a;
        r_el  <= n_el;
        r_dur <= n_dur;
    end
endmodule
`default_nettype wire

// ===== rtl/multi_channel_servo_sweep_ramp.sv =====
// top level of the servo sweep ramp generator: slot table, scan sequencer, result register
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+---------------------
//  in       | input     | i_in_valid/o_in_stall | i_in_data  (t_in)
//  out      | output    | o_out_valid/i_out_stall | o_out_data (t_out)
//  cfg      | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (boards_present)
//
// start and stop scan the slot ram, reading each slot and comparing board and servo on each
// active one. stop all clears every active flag at once. an update walks every slot and, for
// each active slot whose ramp is still running, waits on the interpolator (16 multiply and 16
// divide steps). reset clears the active flags at once; no clearing pass. the block takes one
// item at a time, and a stalled output holds the sequencer until the result register frees.
`default_nettype none
module multi_channel_servo_sweep_ramp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire msr_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output msr_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_data
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_SCAN_END = 4'd3;
    localparam logic [3:0] S_UPD_RD   = 4'd4;
    localparam logic [3:0] S_UPD_CALC = 4'd5;
    localparam logic [3:0] S_UPD_WAIT = 4'd6;
    localparam logic [3:0] S_UPD_PUSH = 4'd7;
    localparam logic [3:0] S_UPD_END  = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    localparam logic [msr_pkg::SLOT_W-1:0] LAST_IDX = msr_pkg::SLOT_W'(msr_pkg::SLOTS - 1);

    logic [3:0]                   r_state, n_state;
    logic [2:0]                   r_boards;
    msr_pkg::t_in                 r_in, n_in;
    logic [msr_pkg::SLOTS-1:0]    r_active, n_active;
    logic [msr_pkg::SLOT_W-1:0]   r_idx, n_idx;
    logic                         r_match_vld, n_match_vld;
    logic [msr_pkg::SLOT_W-1:0]   r_match, n_match;
    logic                         r_free_vld, n_free_vld;
    logic [msr_pkg::SLOT_W-1:0]   r_free, n_free;
    msr_pkg::t_out                r_res, n_res;
    msr_pkg::t_out                r_new, n_new;
    msr_pkg::t_out                r_hold, n_hold;
    logic                         r_hold_vld, n_hold_vld;
    msr_pkg::t_out                r_out, n_out;
    logic                         r_out_vld, n_out_vld;

    logic                         w_we;
    logic [msr_pkg::SLOT_W-1:0]   w_waddr;
    msr_pkg::t_slot               w_wdata, w_rdata;
    logic                         w_out_free, w_load;
    msr_pkg::t_out                w_load_data;
    logic [31:0]                  w_el;
    logic                         w_istart, w_idone;
    logic signed [15:0]           w_ipos;
    logic signed [15:0]           w_sp_clamp, w_ep_clamp;
    logic                         w_bad;

    function automatic logic signed [15:0] clamp_pos(
        input logic signed [15:0] x,
        input logic signed [15:0] c,
        input logic [14:0]        r
    );
        logic signed [16:0] lo, hi, v;
        begin
            lo = $signed({c[15], c}) - $signed({2'b00, r});
            hi = $signed({c[15], c}) + $signed({2'b00, r});
            v  = $signed({x[15], x});
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            if (v > 17'sd32767) begin
                clamp_pos = 16'sh7fff;
            end else if (v < -17'sd32768) begin
                clamp_pos = 16'sh8000;
            end else begin
                clamp_pos = v[15:0];
            end
        end
    endfunction

    msr_ram #(
        .WIDTH($bits(msr_pkg::t_slot)),
        .DEPTH(msr_pkg::SLOTS)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_idx),
        .o_rdata(w_rdata)
    );

    msr_interp u_interp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_istart),
        .i_a    (w_rdata.start_pos),
        .i_b    (w_rdata.end_pos),
        .i_el   (w_el),
        .i_dur  (w_rdata.duration),
        .o_done (w_idone),
        .o_pos  (w_ipos)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_out_free = !r_out_vld || !i_out_stall;
        w_el       = r_in.now_ms - w_rdata.start_time;
        w_sp_clamp = clamp_pos(r_in.start_pos, r_in.limit_center, r_in.limit_range);
        w_ep_clamp = clamp_pos(r_in.end_pos, r_in.limit_center, r_in.limit_range);
        w_bad      = ({1'b0, i_in_data.board} >= r_boards)
                  || ({1'b0, i_in_data.board} >= 3'(msr_pkg::BOARDS))
                  || ({1'b0, i_in_data.servo} >= 5'(msr_pkg::SERVOS));
        w_wdata.board      = r_in.board;
        w_wdata.servo      = r_in.servo;
        w_wdata.start_pos  = w_sp_clamp;
        w_wdata.end_pos    = w_ep_clamp;
        w_wdata.start_time = r_in.now_ms;
        w_wdata.duration   = r_in.duration_ms;
        w_waddr            = r_match_vld ? r_match : r_free;
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_active    = r_active;
        n_idx       = r_idx;
        n_match_vld = r_match_vld;
        n_match     = r_match;
        n_free_vld  = r_free_vld;
        n_free      = r_free;
        n_res       = r_res;
        n_new       = r_new;
        n_hold      = r_hold;
        n_hold_vld  = r_hold_vld;
        w_we        = 1'b0;
        w_istart    = 1'b0;
        w_load      = 1'b0;
        w_load_data = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in               = i_in_data;
                    n_idx              = '0;
                    n_match_vld        = 1'b0;
                    n_free_vld         = 1'b0;
                    n_hold_vld         = 1'b0;
                    n_res.out_board    = i_in_data.board;
                    n_res.out_servo    = i_in_data.servo;
                    n_res.position     = '0;
                    n_res.finished     = 1'b0;
                    n_res.last         = 1'b1;
                    n_res.status       = msr_pkg::ST_ACK;
                    case (i_in_data.kind)
                        msr_pkg::KIND_START: begin
                            if (w_bad) begin
                                n_res.status = msr_pkg::ST_BAD_IDX;
                                n_state      = S_EMIT;
                            end else if (!i_in_data.servo_enabled) begin
                                n_res.status = msr_pkg::ST_DISABLED;
                                n_state      = S_EMIT;
                            end else if (i_in_data.duration_ms == 32'd0) begin
                                n_res.status = msr_pkg::ST_ZERO_DUR;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        msr_pkg::KIND_STOP: begin
                            n_state = S_SCAN_RD;
                        end
                        msr_pkg::KIND_STOP_ALL: begin
                            n_active = '0;
                            n_state  = S_EMIT;
                        end
                        default: begin
                            n_state = S_UPD_RD;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_active[r_idx]) begin
                    n_state = S_SCAN_CMP;
                end else begin
                    if (!r_free_vld) begin
                        n_free_vld = 1'b1;
                        n_free     = r_idx;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_SCAN_END;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_SCAN_CMP: begin
                if (w_rdata.board == r_in.board && w_rdata.servo == r_in.servo) begin
                    n_match_vld = 1'b1;
                    n_match     = r_idx;
                    n_state     = S_SCAN_END;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_END: begin
                n_state = S_EMIT;
                if (r_in.kind == msr_pkg::KIND_STOP) begin
                    if (r_match_vld) begin
                        n_active[r_match] = 1'b0;
                    end
                end else if (r_match_vld || r_free_vld) begin
                    w_we               = 1'b1;
                    n_active[w_waddr]  = 1'b1;
                    n_res.status       = msr_pkg::ST_POSITION;
                    n_res.position     = w_sp_clamp;
                end else begin
                    n_res.status = msr_pkg::ST_NO_SLOT;
                end
            end
            S_UPD_RD: begin
                if (r_active[r_idx]) begin
                    n_state = S_UPD_CALC;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_UPD_END;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_UPD_CALC: begin
                n_new.status    = msr_pkg::ST_POSITION;
                n_new.out_board = w_rdata.board;
                n_new.out_servo = w_rdata.servo;
                n_new.last      = 1'b0;
                if (w_el >= w_rdata.duration) begin
                    n_new.position  = w_rdata.end_pos;
                    n_new.finished  = 1'b1;
                    n_active[r_idx] = 1'b0;
                    n_state         = S_UPD_PUSH;
                end else begin
                    n_new.finished = 1'b0;
                    w_istart       = 1'b1;
                    n_state        = S_UPD_WAIT;
                end
            end
            S_UPD_WAIT: begin
                if (w_idone) begin
                    n_new.position = w_ipos;
                    n_state        = S_UPD_PUSH;
                end
            end
            S_UPD_PUSH: begin
                if (!r_hold_vld || w_out_free) begin
                    if (r_hold_vld) begin
                        w_load      = 1'b1;
                        w_load_data = r_hold;
                    end
                    n_hold     = r_new;
                    n_hold_vld = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_UPD_END;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_UPD_RD;
                    end
                end
            end
            S_UPD_END: begin
                if (r_hold_vld) begin
                    n_res      = r_hold;
                    n_res.last = 1'b1;
                end else begin
                    n_res.status    = msr_pkg::ST_IDLE;
                    n_res.out_board = '0;
                    n_res.out_servo = '0;
                    n_res.position  = '0;
                    n_res.finished  = 1'b0;
                    n_res.last      = 1'b1;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_load_data = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out     = r_out;
        n_out_vld = r_out_vld;
        if (w_load) begin
            n_out     = w_load_data;
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_boards   <= 3'd0;
            r_active   <= '0;
            r_out_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_out_vld  <= n_out_vld;
            r_hold_vld <= n_hold_vld;
            if (i_cfg_valid) begin
                r_boards <= i_cfg_data;
            end
        end
        r_in        <= n_in;
        r_idx       <= n_idx;
        r_match_vld <= n_match_vld;
        r_match     <= n_match;
        r_free_vld  <= n_free_vld;
        r_free      <= n_free;
        r_res       <= n_res;
        r_new       <= n_new;
        r_hold      <= n_hold;
        r_out       <= n_out;
    end
endmodule
`default_nettype wire

// ===== sim/multi_channel_servo_sweep_ramp_test.sv =====
// testbench of the servo sweep ramp generator: directed table, random sweeps, slot table predictor
`timescale 1ns / 100ps
module multi_channel_servo_sweep_ramp_test;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct {
        bit            is_cfg;
        logic [2:0]    cfg;
        msr_pkg::t_in  item;
        bit            typed;
        msr_pkg::t_out res;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    msr_pkg::t_in  i_in_data = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    msr_pkg::t_out o_out_data;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_data = '0;

    multi_channel_servo_sweep_ramp dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor copy of the slot table
    logic [2:0]  boards_cfg;
    bit          sl_act [msr_pkg::SLOTS];
    logic [1:0]  sl_board [msr_pkg::SLOTS];
    logic [3:0]  sl_servo [msr_pkg::SLOTS];
    int          sl_start [msr_pkg::SLOTS];
    int          sl_end [msr_pkg::SLOTS];
    logic [31:0] sl_time [msr_pkg::SLOTS];
    logic [31:0] sl_dur [msr_pkg::SLOTS];

    msr_pkg::t_out cmd_q [$];
    msr_pkg::t_out step_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          hold_req = 0;
    int          burst_left = 0;
    logic [31:0] clock_ms = 0;

    function automatic msr_pkg::t_out mkout(logic [2:0] st, logic [1:0] b, logic [3:0] s,
                                            int pos, bit fin, bit lst);
        msr_pkg::t_out o;
        o.status    = st;
        o.out_board = b;
        o.out_servo = s;
        o.position  = pos[15:0];
        o.finished  = fin;
        o.last      = lst;
        return o;
    endfunction

    function automatic msr_pkg::t_in mkin(logic [1:0] k, logic [1:0] b, logic [3:0] s,
                                          int sp, int ep, logic [31:0] dur, logic [31:0] now,
                                          bit en, int c, int r);
        msr_pkg::t_in t;
        t.kind          = k;
        t.board         = b;
        t.servo         = s;
        t.start_pos     = sp[15:0];
        t.end_pos       = ep[15:0];
        t.duration_ms   = dur;
        t.now_ms        = now;
        t.servo_enabled = en;
        t.limit_center  = c[15:0];
        t.limit_range   = r[14:0];
        return t;
    endfunction

    function automatic int sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int clamp_to(int x, int lo, int hi);
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return sat16(x);
    endfunction

    function automatic int ramp_pos(int a, int b, logic [31:0] el, logic [31:0] dur);
        longint diff;
        longint mag;
        longint q;
        diff = longint'(b) - longint'(a);
        mag  = diff < 0 ? -diff : diff;
        q    = (mag * longint'({32'b0, el})) / longint'({32'b0, dur});
        return sat16(longint'(a) + (diff < 0 ? -q : q));
    endfunction

    task automatic predict_sweep(input msr_pkg::t_in it);
        int slot;
        int lo;
        int hi;
        int sp;
        int ep;
        int n;
        logic [31:0] el;
        step_q.delete();
        slot = -1;
        case (it.kind)
            msr_pkg::KIND_START: begin
                if ({1'b0, it.board} >= boards_cfg) begin
                    step_q.push_back(mkout(msr_pkg::ST_BAD_IDX, it.board, it.servo, 0,
                                           1'b0, 1'b1));
                end else if (!it.servo_enabled) begin
                    step_q.push_back(mkout(msr_pkg::ST_DISABLED, it.board, it.servo, 0,
                                           1'b0, 1'b1));
                end else if (it.duration_ms == 32'd0) begin
                    step_q.push_back(mkout(msr_pkg::ST_ZERO_DUR, it.board, it.servo, 0,
                                           1'b0, 1'b1));
                end else begin
                    lo = int'(it.limit_center) - int'(it.limit_range);
                    hi = int'(it.limit_center) + int'(it.limit_range);
                    sp = clamp_to(int'(it.start_pos), lo, hi);
                    ep = clamp_to(int'(it.end_pos), lo, hi);
                    for (int i = 0; i < msr_pkg::SLOTS; i++)
                        if (slot < 0 && sl_act[i] && sl_board[i] == it.board &&
                            sl_servo[i] == it.servo) slot = i;
                    for (int i = 0; i < msr_pkg::SLOTS; i++)
                        if (slot < 0 && !sl_act[i]) slot = i;
                    if (slot < 0) begin
                        step_q.push_back(mkout(msr_pkg::ST_NO_SLOT, it.board, it.servo, 0,
                                               1'b0, 1'b1));
                    end else begin
                        sl_act[slot]   = 1'b1;
                        sl_board[slot] = it.board;
                        sl_servo[slot] = it.servo;
                        sl_start[slot] = sp;
                        sl_end[slot]   = ep;
                        sl_time[slot]  = it.now_ms;
                        sl_dur[slot]   = it.duration_ms;
                        step_q.push_back(mkout(msr_pkg::ST_POSITION, it.board, it.servo, sp,
                                               1'b0, 1'b1));
                    end
                end
            end
            msr_pkg::KIND_STOP: begin
                for (int i = 0; i < msr_pkg::SLOTS; i++)
                    if (slot < 0 && sl_act[i] && sl_board[i] == it.board &&
                        sl_servo[i] == it.servo) begin
                        slot = i;
                        sl_act[i] = 1'b0;
                    end
                step_q.push_back(mkout(msr_pkg::ST_ACK, it.board, it.servo, 0, 1'b0, 1'b1));
            end
            msr_pkg::KIND_STOP_ALL: begin
                for (int i = 0; i < msr_pkg::SLOTS; i++) sl_act[i] = 1'b0;
                step_q.push_back(mkout(msr_pkg::ST_ACK, it.board, it.servo, 0, 1'b0, 1'b1));
            end
            default: begin
                n = 0;
                for (int i = 0; i < msr_pkg::SLOTS; i++) begin
                    if (sl_act[i]) begin
                        el = it.now_ms - sl_time[i];
                        if (el >= sl_dur[i]) begin
                            step_q.push_back(mkout(msr_pkg::ST_POSITION, sl_board[i],
                                                   sl_servo[i], sl_end[i], 1'b1, 1'b0));
                            sl_act[i] = 1'b0;
                        end else begin
                            step_q.push_back(mkout(msr_pkg::ST_POSITION, sl_board[i],
                                sl_servo[i], ramp_pos(sl_start[i], sl_end[i], el, sl_dur[i]),
                                1'b0, 1'b0));
                        end
                        n++;
                    end
                end
                if (n == 0) step_q.push_back(mkout(msr_pkg::ST_IDLE, 2'd0, 4'd0, 0, 1'b0, 1'b1));
                else step_q[n-1].last = 1'b1;
            end
        endcase
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            if (cmd_q.size() == 0) begin
                $display("%0t unexpected transaction: actual %p", $time, o_out_data);
                errors++;
            end else begin
                msr_pkg::t_out e;
                e = cmd_q.pop_front();
                if (o_out_data.status !== e.status || o_out_data.out_board !== e.out_board ||
                    o_out_data.out_servo !== e.out_servo ||
                    o_out_data.position !== e.position ||
                    o_out_data.finished !== e.finished || o_out_data.last !== e.last) begin
                    $display("%0t mismatch: expected %p actual %p", $time, e, o_out_data);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stall pattern
    initial begin
        int len;
        bit mode;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
            end else begin
                len = mode ? int'($urandom_range(40, 10)) : int'($urandom_range(60, 10));
                for (int k = 0; k < len && !hold_req; k++) begin
                    i_out_stall <= mode ? ($urandom_range(1, 0) == 1) : 1'b0;
                    @(negedge i_clk);
                end
                i_out_stall <= 1'b0;
                mode = !mode;
            end
        end
    end

    task automatic send_item(input msr_pkg::t_in it, input bit typed, input msr_pkg::t_out res);
        if (burst_left == 0) begin
            int gap;
            gap = int'($urandom_range(6, 0));
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = int'($urandom_range(8, 1));
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_sweep(it);
        if (typed) cmd_q.push_back(res);
        else foreach (step_q[k]) cmd_q.push_back(step_q[k]);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_boards(input logic [2:0] v);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        boards_cfg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic msr_pkg::t_in random_item();
        int k;
        logic [31:0] dur;
        k = int'($urandom_range(99, 0));
        if ($urandom_range(9, 0) == 0) clock_ms = $urandom();
        else clock_ms += $urandom_range(500, 0);
        case ($urandom_range(19, 0))
            0: dur = 32'd0;
            1, 2: dur = $urandom();
            default: dur = $urandom_range(2000, 1);
        endcase
        return mkin(k < 45 ? msr_pkg::KIND_START : k < 60 ? msr_pkg::KIND_STOP :
                    k < 65 ? msr_pkg::KIND_STOP_ALL : msr_pkg::KIND_UPDATE,
                    2'($urandom_range(3, 0)), 4'($urandom_range(15, 0)),
                    int'($urandom_range(65535, 0)), int'($urandom_range(65535, 0)), dur,
                    clock_ms, $urandom_range(9, 0) != 0, int'($urandom_range(65535, 0)),
                    int'($urandom_range(32767, 0)));
    endfunction

    initial begin
        t_row rows [$];
        t_row r;
        logic [2:0] phase_cfg [6];
        phase_cfg = '{3'd4, 3'd0, 3'd2, 3'd7, 3'd1, 3'd4};
        boards_cfg = 3'd0;
        foreach (sl_act[i]) sl_act[i] = 1'b0;

        r = '{default: '0}; r.is_cfg = 1; r.cfg = 3'd2; rows.push_back(r);
        r = '{default: '0};
        r.item = mkin(msr_pkg::KIND_START, 2'd2, 4'd0, 0, 0, 32'd5, 32'd0, 1'b1, 0, 100);
        r.typed = 1;
        r.res = mkout(msr_pkg::ST_BAD_IDX, 2'd2, 4'd0, 0, 1'b0, 1'b1); rows.push_back(r);
        r = '{default: '0}; r.is_cfg = 1; r.cfg = 3'd7; rows.push_back(r);
        r = '{default: '0};
        r.item = mkin(msr_pkg::KIND_UPDATE, 2'd0, 4'd0, 0, 0, 32'd0, 32'd0, 1'b0, 0, 0);
        r.typed = 1;
        r.res = mkout(msr_pkg::ST_IDLE, 2'd0, 4'd0, 0, 1'b0, 1'b1); rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_START, 2'd3, 4'd15, 100, 200, 32'd10, 32'd0, 1'b0, 0, 1000);
        r.res = mkout(msr_pkg::ST_DISABLED, 2'd3, 4'd15, 0, 1'b0, 1'b1); rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_START, 2'd1, 4'd2, 100, 200, 32'd0, 32'd0, 1'b1, 0, 1000);
        r.res = mkout(msr_pkg::ST_ZERO_DUR, 2'd1, 4'd2, 0, 1'b0, 1'b1); rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_STOP_ALL, 2'd2, 4'd7, 0, 0, 32'd0, 32'd0, 1'b0, 0, 0);
        r.res = mkout(msr_pkg::ST_ACK, 2'd2, 4'd7, 0, 1'b0, 1'b1); rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_START, 2'd0, 4'd0, -32768, 32767, 32'd1000, 32'd0, 1'b1,
                      0, 32767);
        r.res = mkout(msr_pkg::ST_POSITION, 2'd0, 4'd0, -32767, 1'b0, 1'b1); rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_START, 2'd3, 4'd15, 32767, -32768, 32'hffff_ffff, 32'd100,
                      1'b1, 32767, 32767);
        r.res = mkout(msr_pkg::ST_POSITION, 2'd3, 4'd15, 32767, 1'b0, 1'b1); rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_START, 2'd1, 4'd5, 100, 200, 32'd10, 32'd0, 1'b1, -32768, 0);
        r.res = mkout(msr_pkg::ST_POSITION, 2'd1, 4'd5, -32768, 1'b0, 1'b1); rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_START, 2'd2, 4'd9, -32768, 32767, 32'd7, 32'd0, 1'b1,
                      -32768, 32767);
        r.typed = 0; rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_UPDATE, 2'd0, 4'd0, 0, 0, 32'd0, 32'd500, 1'b0, 0, 0);
        rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_START, 2'd0, 4'd0, 0, 1000, 32'd50, 32'd500, 1'b1, 0, 32767);
        rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_START, 2'd0, 4'd0, -500, 500, 32'd3, 32'd499, 1'b1, 0, 32767);
        rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_UPDATE, 2'd0, 4'd0, 0, 0, 32'd0, 32'd501, 1'b0, 0, 0);
        rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_UPDATE, 2'd0, 4'd0, 0, 0, 32'd0, 32'd400, 1'b0, 0, 0);
        rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_START, 2'd2, 4'd3, 1000, -1000, 32'h8000_0000,
                      32'hffff_fff0, 1'b1, 0, 2000);
        rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_UPDATE, 2'd0, 4'd0, 0, 0, 32'd0, 32'h0000_0100, 1'b0, 0, 0);
        rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_STOP, 2'd2, 4'd3, 0, 0, 32'd0, 32'd0, 1'b0, 0, 0);
        r.typed = 1;
        r.res = mkout(msr_pkg::ST_ACK, 2'd2, 4'd3, 0, 1'b0, 1'b1); rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_STOP, 2'd2, 4'd2, 0, 0, 32'd0, 32'd0, 1'b0, 0, 0);
        r.res = mkout(msr_pkg::ST_ACK, 2'd2, 4'd2, 0, 1'b0, 1'b1); rows.push_back(r);
        r.item = mkin(msr_pkg::KIND_UPDATE, 2'd3, 4'd15, -1, -1, 32'hffff_ffff, 32'hffff_ffff,
                      1'b1, -1, 32767);
        r.typed = 0; rows.push_back(r);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_boards(rows[i].cfg);
            else send_item(rows[i].item, rows[i].typed, rows[i].res);
        end

        for (int p = 0; p < 6; p++) begin
            write_boards(phase_cfg[p]);
            for (int n = 0; n < 20; n++) begin
                if (p == 0 && n == 8) hold_req = 1;
                if (p == 3 && n == 12) drain_results();
                send_item(random_item(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (2500) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/msr_pkg.sv
rtl/msr_ram.sv
rtl/msr_interp.sv
rtl/multi_channel_servo_sweep_ramp.sv
sim/multi_channel_servo_sweep_ramp_test.sv
